// File: src/gass_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Glyph atlas size search package
// Shared constants, storage types and the command and result records that
// pass between the loader at the top level and the search sequencer.
// ----------------------------------------------------------------------------
package gass_pkg;

    localparam int MAX_GLYPHS = 512;
    localparam int PAD_PIXELS = 2;

    localparam int CNT_W  = $clog2(MAX_GLYPHS + 1);
    localparam int ADDR_W = (MAX_GLYPHS > 1) ? $clog2(MAX_GLYPHS) : 1;

    localparam int IN_W  = 12;
    localparam int PIX_W = 8;
    localparam int DIM_W = 13;

    localparam int MAX_W      = 255 - PAD_PIXELS;
    localparam int MAX_H      = 255;
    localparam int START_SIZE = 128;
    localparam int LIMIT_SIZE = 2048;

    typedef logic [DIM_W-1:0]   dim_t;
    typedef logic [2*PIX_W-1:0] entry_t;

    typedef struct packed {
        logic             start;
        logic [CNT_W-1:0] count;
        logic             overflow;
        logic             mode;
    } search_cmd_t;

    typedef struct packed {
        logic done;
        dim_t width;
        dim_t height;
        logic fits;
        logic overflow;
    } search_res_t;

endpackage

// File: src/gass_store.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Glyph size store
// Simple dual-port memory of clamped glyph sizes, height in the upper byte
// and width in the lower byte. Read data is registered.
// ----------------------------------------------------------------------------
module gass_store (
    input  logic                   clk,
    input  logic                   wr_en,
    input  logic [gass_pkg::ADDR_W-1:0] wr_addr,
    input  gass_pkg::entry_t       wr_data,
    input  logic                   rd_en,
    input  logic [gass_pkg::ADDR_W-1:0] rd_addr,
    output gass_pkg::entry_t       rd_data
);
    import gass_pkg::*;

    entry_t mem [MAX_GLYPHS];
    entry_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: src/gass_search.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Atlas size search sequencer
// Runs shelf-packing trials over the stored glyphs, one glyph at a time,
// and grows the trial size until every glyph fits or the size passes the
// limit.
// ----------------------------------------------------------------------------
module gass_search (
    input  logic                    clk,
    input  logic                    rst_n,
    input  gass_pkg::search_cmd_t   cmd,
    input  logic                    res_take,
    output gass_pkg::search_res_t   res,
    output logic                    busy,
    output logic                    rd_en,
    output logic [gass_pkg::ADDR_W-1:0] rd_addr,
    input  gass_pkg::entry_t        rd_data
);
    import gass_pkg::*;

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_TRIAL = 7'b0000010,
        S_FETCH = 7'b0000100,
        S_PLACE = 7'b0001000,
        S_TEST  = 7'b0010000,
        S_GROW  = 7'b0100000,
        S_WIN   = 7'b1000000
    } state_t;

    // A result waiting to be taken is held in the idle state with done_reg set.
    state_t           state_reg, state_next;
    logic             done_reg, done_next;
    dim_t             tw_reg, tw_next;
    dim_t             th_reg, th_next;
    dim_t             pen_x_reg, pen_x_next;
    dim_t             pen_y_reg, pen_y_next;
    dim_t             rb_reg, rb_next;
    logic [CNT_W-1:0] idx_reg, idx_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             mode_reg, mode_next;
    logic             ovf_reg, ovf_next;
    logic             fits_reg, fits_next;

    logic [PIX_W-1:0] gw;
    logic [PIX_W-1:0] gh;
    logic [DIM_W:0]   sum_x;
    logic [DIM_W:0]   bottom;
    logic [CNT_W-1:0] idx_inc;
    logic             over_limit;

    assign gw      = rd_data[PIX_W-1:0];
    assign gh      = rd_data[2*PIX_W-1:PIX_W];
    assign sum_x   = {1'b0, pen_x_reg} + (DIM_W+1)'(gw) + (DIM_W+1)'(PAD_PIXELS);
    assign bottom  = {1'b0, pen_y_reg} + (DIM_W+1)'(gh);
    assign idx_inc = idx_reg + CNT_W'(1);
    assign over_limit = (tw_reg > DIM_W'(LIMIT_SIZE)) || (th_reg > DIM_W'(LIMIT_SIZE));

    always_comb
    begin
        state_next = state_reg;
        done_next  = done_reg;
        tw_next    = tw_reg;
        th_next    = th_reg;
        pen_x_next = pen_x_reg;
        pen_y_next = pen_y_reg;
        rb_next    = rb_reg;
        idx_next   = idx_reg;
        cnt_next   = cnt_reg;
        mode_next  = mode_reg;
        ovf_next   = ovf_reg;
        fits_next  = fits_reg;
        rd_en      = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (done_reg)
                begin
                    if (res_take)
                    begin
                        done_next = 1'b0;
                    end
                end
                else if (cmd.start)
                begin
                    cnt_next   = cmd.count;
                    mode_next  = cmd.mode;
                    ovf_next   = cmd.overflow;
                    tw_next    = DIM_W'(START_SIZE);
                    th_next    = DIM_W'(START_SIZE);
                    state_next = S_TRIAL;
                end
            end
            S_TRIAL:
            begin
                pen_x_next = DIM_W'(PAD_PIXELS);
                pen_y_next = DIM_W'(PAD_PIXELS);
                rb_next    = DIM_W'(PAD_PIXELS);
                idx_next   = '0;
                if (over_limit)
                begin
                    fits_next  = 1'b0;
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
                else if (cnt_reg == '0)
                begin
                    state_next = S_WIN;
                end
                else
                begin
                    state_next = S_FETCH;
                end
            end
            S_FETCH:
            begin
                rd_en      = 1'b1;
                state_next = S_PLACE;
            end
            S_PLACE:
            begin
                // A glyph that runs past the right edge opens a new row.
                if (sum_x > (DIM_W+1)'(tw_reg))
                begin
                    pen_x_next = DIM_W'(gw) + DIM_W'(2 * PAD_PIXELS);
                    pen_y_next = rb_reg + DIM_W'(PAD_PIXELS);
                end
                else
                begin
                    pen_x_next = sum_x[DIM_W-1:0];
                end
                state_next = S_TEST;
            end
            S_TEST:
            begin
                if (bottom > (DIM_W+1)'(th_reg))
                begin
                    state_next = S_GROW;
                end
                else
                begin
                    if (bottom > (DIM_W+1)'(rb_reg))
                    begin
                        rb_next = bottom[DIM_W-1:0];
                    end
                    idx_next   = idx_inc;
                    state_next = (idx_inc == cnt_reg) ? S_WIN : S_FETCH;
                end
            end
            S_GROW:
            begin
                if (th_reg < tw_reg)
                begin
                    th_next = {th_reg[DIM_W-2:0], 1'b0};
                end
                else
                begin
                    tw_next = {tw_reg[DIM_W-2:0], 1'b0};
                    if (!mode_reg)
                    begin
                        th_next = {1'b0, th_reg[DIM_W-1:1]};
                    end
                end
                state_next = S_TRIAL;
            end
            S_WIN:
            begin
                fits_next = 1'b1;
                if (mode_reg)
                begin
                    th_next = rb_reg + DIM_W'(rb_reg[0]);
                end
                done_next  = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            done_reg  <= 1'b0;
            tw_reg    <= DIM_W'(START_SIZE);
            th_reg    <= DIM_W'(START_SIZE);
            pen_x_reg <= DIM_W'(PAD_PIXELS);
            pen_y_reg <= DIM_W'(PAD_PIXELS);
            rb_reg    <= DIM_W'(PAD_PIXELS);
            idx_reg   <= '0;
            cnt_reg   <= '0;
            mode_reg  <= 1'b0;
            ovf_reg   <= 1'b0;
            fits_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
            tw_reg    <= tw_next;
            th_reg    <= th_next;
            pen_x_reg <= pen_x_next;
            pen_y_reg <= pen_y_next;
            rb_reg    <= rb_next;
            idx_reg   <= idx_next;
            cnt_reg   <= cnt_next;
            mode_reg  <= mode_next;
            ovf_reg   <= ovf_next;
            fits_reg  <= fits_next;
        end
    end

    assign rd_addr      = idx_reg[ADDR_W-1:0];
    assign busy         = (state_reg != S_IDLE) || done_reg;
    assign res.done     = done_reg;
    assign res.width    = tw_reg;
    assign res.height   = th_reg;
    assign res.fits     = fits_reg;
    assign res.overflow = ovf_reg;

endmodule

// File: src/glyph_atlas_size_search.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Glyph atlas size search
// Loads clamped glyph sizes into a store, one item per cycle while no search is
// running, and on the last item searches for the smallest shelf-packed texture that holds them all.
// ----------------------------------------------------------------------------
// Loading: one item per cycle while no search is running or waiting for its result to be taken.
// Search: each trial sets up, then reads, places and tests each glyph in turn,
// and ends by growing the trial size or finishing.
// At most 13 trials run (9 in non-power-of-two mode), plus one size check on failure.
// The result register loads once the search ends and the output register is free; the input is held off until then.
// Reset (rst_n, async, active low) clears count, flags, mode and handshakes, not the store.
module glyph_atlas_size_search (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic                       glyph_present,
    input  logic [gass_pkg::IN_W-1:0]  glyph_width,
    input  logic [gass_pkg::IN_W-1:0]  glyph_height,
    input  logic                       last_glyph,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic [gass_pkg::DIM_W-1:0] texture_width,
    output logic [gass_pkg::DIM_W-1:0] texture_height,
    output logic                       fits,
    output logic                       store_overflow,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic                       cfg_data
);
    import gass_pkg::*;

    logic [CNT_W-1:0] count_reg, count_next;
    logic             ovf_reg, ovf_next;
    logic             mode_reg;
    logic             out_valid_reg;
    dim_t             out_w_reg;
    dim_t             out_h_reg;
    logic             out_fits_reg;
    logic             out_ovf_reg;

    logic             in_acc;
    logic             store_full;
    logic             wr_en;
    entry_t           wr_data;
    logic [PIX_W-1:0] clamp_w;
    logic [PIX_W-1:0] clamp_h;
    logic             busy;
    logic             res_take;
    logic             rd_en;
    logic [ADDR_W-1:0] rd_addr;
    entry_t           rd_data;
    search_cmd_t      cmd;
    search_res_t      res;

    assign in_ready   = !busy;
    assign in_acc     = in_valid && in_ready;
    assign store_full = (count_reg >= CNT_W'(MAX_GLYPHS));
    assign wr_en      = in_acc && glyph_present && !store_full;

    assign clamp_w = (glyph_width > IN_W'(MAX_W)) ? PIX_W'(MAX_W) : glyph_width[PIX_W-1:0];
    assign clamp_h = (glyph_height > IN_W'(MAX_H)) ? PIX_W'(MAX_H) : glyph_height[PIX_W-1:0];
    assign wr_data = {clamp_h, clamp_w};

    always_comb
    begin
        count_next = count_reg;
        ovf_next   = ovf_reg;
        if (in_acc && glyph_present)
        begin
            if (store_full)
            begin
                ovf_next = 1'b1;
            end
            else
            begin
                count_next = count_reg + CNT_W'(1);
            end
        end
    end

    // The last item hands its set to the search, and the next item opens a new set.
    assign cmd.start    = in_acc && last_glyph;
    assign cmd.count    = count_next;
    assign cmd.overflow = ovf_next;
    assign cmd.mode     = mode_reg;

    assign res_take  = res.done && (!out_valid_reg || out_ready);
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            ovf_reg       <= 1'b0;
            mode_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.start)
            begin
                count_reg <= '0;
                ovf_reg   <= 1'b0;
            end
            else
            begin
                count_reg <= count_next;
                ovf_reg   <= ovf_next;
            end
            if (cfg_valid && cfg_ready)
            begin
                mode_reg <= cfg_data;
            end
            if (res_take)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_take)
        begin
            out_w_reg    <= res.width;
            out_h_reg    <= res.height;
            out_fits_reg <= res.fits;
            out_ovf_reg  <= res.overflow;
        end
    end

    gass_store u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (count_reg[ADDR_W-1:0]),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    gass_search u_search (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .res_take (res_take),
        .res      (res),
        .busy     (busy),
        .rd_en    (rd_en),
        .rd_addr  (rd_addr),
        .rd_data  (rd_data)
    );

    assign out_valid      = out_valid_reg;
    assign texture_width  = out_w_reg;
    assign texture_height = out_h_reg;
    assign fits           = out_fits_reg;
    assign store_overflow = out_ovf_reg;

endmodule

// File: src/gass_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Glyph atlas size search checker
// Port-level properties of the search block, bound to the top level.
// ----------------------------------------------------------------------------
module gass_checker (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    input  logic                       in_ready,
    input  logic                       last_glyph,
    input  logic                       out_valid,
    input  logic                       out_ready,
    input  logic [gass_pkg::DIM_W-1:0] texture_width,
    input  logic [gass_pkg::DIM_W-1:0] texture_height,
    input  logic                       fits,
    input  logic                       store_overflow
);
    import gass_pkg::*;

    // The last item always starts a search, which holds the input off.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && last_glyph |=> !in_ready)
        else $error("input still ready after the last item");

    // A result only appears at the end of a search.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(!in_ready))
        else $error("result without a search");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && fits |->
            texture_width >= DIM_W'(START_SIZE) && texture_width <= DIM_W'(LIMIT_SIZE)
            && texture_height <= DIM_W'(LIMIT_SIZE))
        else $error("fitting result outside the size limit");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !fits |->
            texture_width > DIM_W'(LIMIT_SIZE) || texture_height > DIM_W'(LIMIT_SIZE))
        else $error("failed result within the size limit");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(texture_width)
            && $stable(texture_height) && $stable(fits) && $stable(store_overflow))
        else $error("stalled result changed");

endmodule

bind glyph_atlas_size_search gass_checker u_gass_checker (.*);

// File: dv/tb_glyph_atlas_size_search.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Glyph atlas size search testbench
// Streams sets of glyph sizes into the block and predicts the texture size
// that shelf packing settles on for each set. Every result is compared
// field by field against the prediction, in both height modes and under
// random idling on both handshakes.
// ----------------------------------------------------------------------------
module tb_glyph_atlas_size_search;
    import gass_pkg::*;

    localparam int CLK_HALF      = 5;
    localparam int RESET_CYCLES  = 10;
    localparam int SETTLE_CYCLES = 50;
    localparam int HOLD_CYCLES   = 600;
    localparam int RANDOM_ITEMS  = 200;
    localparam int WIDE_SET_SIZE = 60;
    localparam int FULL_SET_SIZE = MAX_GLYPHS + 8;
    // The limit covers the slowest legal run: at most 13 trials per set,
    // each over every stored glyph, plus random gaps and stalls.
    localparam int LIMIT_CYCLES  = 2000000;

    typedef struct packed {
        logic            present;
        logic [IN_W-1:0] w;
        logic [IN_W-1:0] h;
        logic            last;
    } glyph_item_t;

    typedef struct packed {
        dim_t width;
        dim_t height;
        logic fits;
        logic overflow;
    } atlas_result_t;

    logic             clk;
    logic             rst_n          = 1'b0;
    logic             in_valid       = 1'b0;
    logic             in_ready;
    logic             glyph_present  = 1'b0;
    logic [IN_W-1:0]  glyph_width    = '0;
    logic [IN_W-1:0]  glyph_height   = '0;
    logic             last_glyph     = 1'b0;
    logic             out_valid;
    logic             out_ready      = 1'b0;
    logic [DIM_W-1:0] texture_width;
    logic [DIM_W-1:0] texture_height;
    logic             fits;
    logic             store_overflow;
    logic             cfg_valid      = 1'b0;
    logic             cfg_ready;
    logic             cfg_data       = 1'b0;

    glyph_item_t   glyph_q[$];
    glyph_item_t   next_glyph;
    atlas_result_t atlas_expect_q[$];
    atlas_result_t want_res;

    // Predicted block state.
    logic [PIX_W-1:0] store_w[MAX_GLYPHS];
    logic [PIX_W-1:0] store_h[MAX_GLYPHS];
    int unsigned      stored_n   = 0;
    bit               store_lost = 1'b0;
    bit               pred_mode  = 1'b0;

    int unsigned tx_idle_pct    = 0;
    int unsigned rx_idle_pct    = 0;
    logic        hold_req       = 1'b0;
    logic        rx_hold        = 1'b0;
    int unsigned items_queued   = 0;
    int unsigned items_taken    = 0;
    int unsigned glyphs_offered = 0;
    int unsigned results_seen   = 0;
    int unsigned failed_seen    = 0;
    int unsigned overflow_seen  = 0;
    int unsigned mismatch_count = 0;
    int unsigned cycle_count    = 0;

    glyph_atlas_size_search uut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .glyph_present  (glyph_present),
        .glyph_width    (glyph_width),
        .glyph_height   (glyph_height),
        .last_glyph     (last_glyph),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .texture_width  (texture_width),
        .texture_height (texture_height),
        .fits           (fits),
        .store_overflow (store_overflow),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_data       (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #CLK_HALF clk = ~clk;
    end

    // Packs the stored glyphs into shelves at one trial size.
    function automatic bit pack_shelves(input int unsigned trial_w, input int unsigned trial_h,
                                        output int unsigned shelf_bottom);
        int unsigned pen_x;
        int unsigned pen_y;
        int unsigned bottom;
        int unsigned n;
        pen_x = PAD_PIXELS;
        pen_y = PAD_PIXELS;
        shelf_bottom = PAD_PIXELS;
        for (n = 0; n < stored_n; n++)
        begin
            // Only heights are tested, so an overly wide glyph still gets a row.
            if (pen_x + PAD_PIXELS + store_w[n] > trial_w)
            begin
                pen_x = PAD_PIXELS;
                pen_y = shelf_bottom + PAD_PIXELS;
            end
            pen_x += store_w[n] + PAD_PIXELS;
            bottom = pen_y + store_h[n];
            if (bottom > trial_h)
                return 1'b0;
            if (bottom > shelf_bottom)
                shelf_bottom = bottom;
        end
        return 1'b1;
    endfunction

    // Loads one accepted item; the last item of a set runs the size search.
    function automatic void load_glyph(input glyph_item_t g);
        int unsigned   tw;
        int unsigned   th;
        int unsigned   bottom;
        bit            ok;
        atlas_result_t res;
        if (g.present)
        begin
            if (stored_n < MAX_GLYPHS)
            begin
                store_w[stored_n] = (g.w > MAX_W) ? PIX_W'(MAX_W) : g.w[PIX_W-1:0];
                store_h[stored_n] = (g.h > MAX_H) ? PIX_W'(MAX_H) : g.h[PIX_W-1:0];
                stored_n++;
            end
            else
                store_lost = 1'b1;
        end
        if (g.last)
        begin
            tw = START_SIZE;
            th = START_SIZE;
            ok = 1'b0;
            while (tw <= LIMIT_SIZE && th <= LIMIT_SIZE)
            begin
                if (pack_shelves(tw, th, bottom))
                begin
                    ok = 1'b1;
                    if (pred_mode)
                        th = bottom + (bottom & 1);
                    break;
                end
                if (th < tw)
                    th = th * 2;
                else
                begin
                    tw = tw * 2;
                    if (!pred_mode)
                        th = th / 2;
                end
            end
            res.width    = tw[DIM_W-1:0];
            res.height   = th[DIM_W-1:0];
            res.fits     = ok;
            res.overflow = store_lost;
            atlas_expect_q = {atlas_expect_q, res};
            stored_n   = 0;
            store_lost = 1'b0;
        end
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("ERROR result %0d %s: got %0d, want %0d", results_seen, what, got, want);
        mismatch_count++;
    endtask

    function automatic void queue_glyph(input logic present, input logic [IN_W-1:0] w,
                                        input logic [IN_W-1:0] h, input logic last);
        glyph_item_t g;
        g.present = present;
        g.w       = w;
        g.h       = h;
        g.last    = last;
        glyph_q = {glyph_q, g};
        items_queued++;
        if (present || last)
            glyphs_offered++;
    endfunction

    function automatic logic [IN_W-1:0] pick_size(input int unsigned scale);
        if ($urandom_range(0, 99) < 15)
            return IN_W'($urandom_range(0, (1 << IN_W) - 1));
        return IN_W'($urandom_range(0, scale));
    endfunction

    // One set of random glyphs; most sets are short, a few run longer.
    function automatic void add_random_set();
        int unsigned n;
        int unsigned k;
        int unsigned scale;
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
        case ($urandom_range(0, 2))
            0: scale = 15;
            1: scale = 63;
            default: scale = 255;
        endcase
        for (k = 0; k < n; k++)
            queue_glyph($urandom_range(0, 9) != 0, pick_size(scale), pick_size(scale),
                        k == n - 1);
    endfunction

    function automatic void add_random_phase(input int unsigned target);
        int unsigned start;
        start = glyphs_offered;
        while (glyphs_offered - start < target)
            add_random_set();
    endfunction

    // Large glyphs only, enough that even 2048 by 2048 cannot hold them.
    function automatic void add_wide_set();
        int unsigned k;
        for (k = 0; k < WIDE_SET_SIZE; k++)
            queue_glyph(1'b1, IN_W'($urandom_range(MAX_W, 4095)),
                        IN_W'($urandom_range(MAX_H, 4095)), k == WIDE_SET_SIZE - 1);
    endfunction

    task automatic wait_drained();
        while (items_taken != items_queued || atlas_expect_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_mode(input logic value);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        pred_mode = value;
    endtask

    // Sender: offers the next queued item when the slot is free, idling at random.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid      <= 1'b0;
            glyph_present <= 1'b0;
            glyph_width   <= '0;
            glyph_height  <= '0;
            last_glyph    <= 1'b0;
        end
        else if (!in_valid || in_ready)
        begin
            if (glyph_q.size() != 0 && $urandom_range(0, 99) >= tx_idle_pct)
            begin
                next_glyph    = glyph_q.pop_front();
                in_valid      <= 1'b1;
                glyph_present <= next_glyph.present;
                glyph_width   <= next_glyph.w;
                glyph_height  <= next_glyph.h;
                last_glyph    <= next_glyph.last;
            end
            else
                in_valid <= 1'b0;
        end
    end

    // Receiver: random stalls, plus one long hold-off.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else
            out_ready <= !rx_hold && ($urandom_range(0, 99) >= rx_idle_pct);
    end

    initial
    begin
        wait (hold_req);
        @(posedge clk);
        rx_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        rx_hold <= 1'b0;
    end

    // Monitor: predicts on each accepted item and checks each accepted result.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && in_ready)
            begin
                load_glyph({glyph_present, glyph_width, glyph_height, last_glyph});
                items_taken++;
            end
            if (out_valid && out_ready)
            begin
                results_seen++;
                if (!fits)
                    failed_seen++;
                if (store_overflow)
                    overflow_seen++;
                if (atlas_expect_q.size() == 0)
                begin
                    report_mismatch("unexpected result", 32'd1, 32'd0);
                end
                else
                begin
                    want_res = atlas_expect_q.pop_front();
                    if (texture_width !== want_res.width)
                        report_mismatch("texture_width", 32'(texture_width),
                                        32'(want_res.width));
                    if (texture_height !== want_res.height)
                        report_mismatch("texture_height", 32'(texture_height),
                                        32'(want_res.height));
                    if (fits !== want_res.fits)
                        report_mismatch("fits", 32'(fits), 32'(want_res.fits));
                    if (store_overflow !== want_res.overflow)
                        report_mismatch("store_overflow", 32'(store_overflow),
                                        32'(want_res.overflow));
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES)
        begin
            $display("Timeout after %0d cycles with %0d results still pending",
                     cycle_count, atlas_expect_q.size());
            $display("Mismatches found");
            $finish;
        end
    end

    initial
    begin
        int unsigned k;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        tx_idle_pct <= 15;
        rx_idle_pct <= 48;
        write_mode(1'b0);

        // Empty store, then single glyphs at the size extremes.
        queue_glyph(1'b0, 12'd0, 12'd0, 1'b1);
        queue_glyph(1'b1, 12'd0, 12'd0, 1'b1);
        queue_glyph(1'b1, 12'hFFF, 12'hFFF, 1'b1);
        // Values around both clamps, with an absent glyph in the middle.
        queue_glyph(1'b1, 12'd253, 12'd255, 1'b0);
        queue_glyph(1'b1, 12'd254, 12'd256, 1'b0);
        queue_glyph(1'b1, 12'd255, 12'hFFF, 1'b0);
        queue_glyph(1'b0, 12'hFFF, 12'hFFF, 1'b0);
        queue_glyph(1'b1, 12'd1, 12'd1, 1'b0);
        queue_glyph(1'b1, 12'd2048, 12'd1, 1'b0);
        queue_glyph(1'b1, 12'd1, 12'd2048, 1'b1);
        queue_glyph(1'b1, 12'hAAA, 12'h555, 1'b0);
        queue_glyph(1'b1, 12'h555, 12'hAAA, 1'b0);
        queue_glyph(1'b1, 12'h0FF, 12'h0FE, 1'b0);
        queue_glyph(1'b1, 12'h100, 12'h0FD, 1'b1);
        // A set whose last item carries no glyph.
        queue_glyph(1'b1, 12'd10, 12'd20, 1'b0);
        queue_glyph(1'b1, 12'd30, 12'd40, 1'b0);
        queue_glyph(1'b0, 12'd7, 12'd9, 1'b1);
        // Exactly the first trial size, and one pixel past it each way.
        queue_glyph(1'b1, 12'd124, 12'd126, 1'b1);
        queue_glyph(1'b1, 12'd125, 12'd127, 1'b1);

        add_wide_set();
        // More glyphs than the store holds; the extra ones are dropped.
        for (k = 0; k < FULL_SET_SIZE; k++)
            queue_glyph(1'b1, IN_W'($urandom_range(0, 15)), IN_W'($urandom_range(0, 15)),
                        k == FULL_SET_SIZE - 1);
        wait_drained();

        write_mode(1'b1);
        queue_glyph(1'b0, 12'd0, 12'd0, 1'b1);
        add_random_phase(RANDOM_ITEMS);
        add_wide_set();
        wait_drained();

        // The receiver holds off while the sender keeps offering items.
        tx_idle_pct <= 48;
        rx_idle_pct <= 15;
        hold_req    <= 1'b1;
        write_mode(1'b0);
        add_random_phase(RANDOM_ITEMS);
        wait_drained();

        tx_idle_pct <= 0;
        rx_idle_pct <= 0;
        write_mode(1'b1);
        add_random_phase(RANDOM_ITEMS);
        wait_drained();

        $display("Run covered %0d items and %0d atlas results in both height modes,",
                 items_taken, results_seen);
        $display("including %0d failed searches and %0d store overflows.",
                 failed_seen, overflow_seen);
        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
